FILE: sv/udiv64_pkg.sv
package udiv64_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

endpackage

FILE: sv/udiv64_if.sv
interface udiv64_req_if #(
   parameter int DATA_WIDTH = 64
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] dividend;
   logic [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface udiv64_rsp_if #(
   parameter int DATA_WIDTH = 64
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] quotient;
   logic [DATA_WIDTH-1:0] remainder;
   logic                  divide_by_zero;

   modport source (output valid, output quotient, output remainder,
                   output divide_by_zero, input ready);
   modport sink (input valid, input quotient, input remainder,
                 input divide_by_zero, output ready);
endinterface

FILE: sv/udiv64_cell.sv
module udiv64_cell (
   input  logic                      clock,
   input  udiv64_pkg::cell_ctrl_type ctrl,
   input  logic                      load_dividend,
   input  logic                      load_divisor,
   input  logic                      part_lo,
   input  logic                      nq_lo,
   input  logic                      borrow_lo,
   input  logic                      take,
   output logic                      part_bit,
   output logic                      nq_bit,
   output logic                      borrow_hi
);

   logic part_ff;
   logic part_in;
   logic nq_ff;
   logic nq_in;
   logic dvs_ff;
   logic dvs_in;
   logic diff;

   // One bit of the shifted partial remainder minus the divisor.
   assign diff      = part_lo ^ dvs_ff ^ borrow_lo;
   assign borrow_hi = (~part_lo & dvs_ff) | (~(part_lo ^ dvs_ff) & borrow_lo);

   always_comb begin
      priority if (ctrl.load) begin
         part_in = 1'b0;
         nq_in   = load_dividend;
         dvs_in  = load_divisor;
      end else if (ctrl.step) begin
         part_in = take ? diff : part_lo;
         nq_in   = nq_lo;
         dvs_in  = dvs_ff;
      end else begin
         part_in = part_ff;
         nq_in   = nq_ff;
         dvs_in  = dvs_ff;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      nq_ff   <= nq_in;
      dvs_ff  <= dvs_in;
   end

   assign part_bit = part_ff;
   assign nq_bit   = nq_ff;

endmodule

FILE: sv/udiv64_row.sv
module udiv64_row #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                      clock,
   input  udiv64_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]     dividend,
   input  logic [DATA_WIDTH-1:0]     divisor,
   output logic [DATA_WIDTH-1:0]     part,
   output logic [DATA_WIDTH-1:0]     nq
);

   logic [DATA_WIDTH:0] borrow;
   logic                take;

   assign borrow[0] = 1'b0;

   // Subtract when the bit shifted out was set or no borrow leaves the top.
   assign take = part[DATA_WIDTH-1] | ~borrow[DATA_WIDTH];

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      logic part_lo;
      logic nq_lo;

      if (i == 0) begin : g_low
         assign part_lo = nq[DATA_WIDTH-1];
         assign nq_lo   = take;
      end else begin : g_mid
         assign part_lo = part[i-1];
         assign nq_lo   = nq[i-1];
      end

      udiv64_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .load_dividend (dividend[i]),
         .load_divisor  (divisor[i]),
         .part_lo       (part_lo),
         .nq_lo         (nq_lo),
         .borrow_lo     (borrow[i]),
         .take          (take),
         .part_bit      (part[i]),
         .nq_bit        (nq[i]),
         .borrow_hi     (borrow[i+1])
      );
   end

endmodule

FILE: sv/unsigned_divide_64.sv
// Unsigned restoring divider built as a row of one-bit cells.
// A request on req_chan carries dividend and divisor; it is accepted when
// valid and ready are both high. The response on rsp_chan carries quotient,
// remainder and divide_by_zero, and is taken when valid and ready are high.
// Each cell holds one bit of the partial remainder, the divisor and the
// dividend/quotient shift register, and the borrow ripples through the row.
// One quotient bit is decided per cycle: a request is loaded into the row,
// steps once per quotient bit, and then moves its result to the output
// register. One request is in the row at a time; a new request is accepted
// in the cycle the finished result moves out. A zero divisor gives zero
// quotient and remainder with divide_by_zero set. When the receiver stalls,
// the output register holds its response, the next result waits in the row,
// and req_chan.ready stays low until the output register frees up.
// Synchronous reset empties the output register and returns the block to
// idle with ready high.
module unsigned_divide_64 #(
   parameter int DATA_WIDTH = 64
) (
   input logic         clock,
   input logic         reset,
   udiv64_req_if.sink  req_chan,
   udiv64_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

   udiv64_pkg::state_type     state_ff;
   udiv64_pkg::state_type     state_in;
   udiv64_pkg::cell_ctrl_type ctrl;

   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic                  dz_ff;
   logic                  dz_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] quotient_ff;
   logic [DATA_WIDTH-1:0] quotient_in;
   logic [DATA_WIDTH-1:0] remainder_ff;
   logic [DATA_WIDTH-1:0] remainder_in;
   logic                  rsp_dz_ff;
   logic                  rsp_dz_in;
   logic [DATA_WIDTH-1:0] part;
   logic [DATA_WIDTH-1:0] nq;
   logic                  out_free;
   logic                  out_load;
   logic                  req_ready;

   udiv64_row #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_row (
      .clock    (clock),
      .ctrl     (ctrl),
      .dividend (req_chan.dividend),
      .divisor  (req_chan.divisor),
      .part     (part),
      .nq       (nq)
   );

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         udiv64_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = udiv64_pkg::ST_BUSY;
            end
         end
         udiv64_pkg::ST_BUSY: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = udiv64_pkg::ST_DONE;
            end
         end
         udiv64_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = req_chan.valid ? udiv64_pkg::ST_BUSY : udiv64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = udiv64_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      ctrl.step = 1'b0;
      unique case (state_ff)
         udiv64_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         udiv64_pkg::ST_BUSY: begin
            ctrl.step = 1'b1;
         end
         udiv64_pkg::ST_DONE: begin
            req_ready = out_free;
            out_load  = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      ctrl.load = req_ready & req_chan.valid;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         cnt_in = '0;
      end else if (ctrl.step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign dz_in        = ctrl.load ? ~(|req_chan.divisor) : dz_ff;
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_chan.ready);
   assign quotient_in  = out_load ? (dz_ff ? '0 : nq) : quotient_ff;
   assign remainder_in = out_load ? (dz_ff ? '0 : part) : remainder_ff;
   assign rsp_dz_in    = out_load ? dz_ff : rsp_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udiv64_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dz_ff        <= dz_in;
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.quotient       = quotient_ff;
   assign rsp_chan.remainder      = remainder_ff;
   assign rsp_chan.divide_by_zero = rsp_dz_ff;

endmodule

FILE: sv/udiv64_checker.sv
module udiv64_sva #(
   parameter int DATA_WIDTH = 64
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_quotient,
   input logic [DATA_WIDTH-1:0] rsp_remainder,
   input logic                  rsp_divide_by_zero
);

   // Reset leaves no response pending and the block ready for a request.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // Only one request is worked on at a time.
   a_one_in_row: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the row is busy");

   a_zero_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (rsp_quotient == '0 && rsp_remainder == '0))
      else $error("nonzero result for a zero divisor");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_quotient) && $stable(rsp_remainder) &&
          $stable(rsp_divide_by_zero)))
      else $error("response changed while stalled");

endmodule

bind unsigned_divide_64 udiv64_sva #(
   .DATA_WIDTH (DATA_WIDTH)
) u_udiv64_sva (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_quotient       (rsp_chan.quotient),
   .rsp_remainder      (rsp_chan.remainder),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero)
);

FILE: tb/udiv64_checker.sv
`timescale 1ns / 1ps

module udiv64_checker #(
   parameter int W = 64
) (
   input  logic  clock,
   input  logic  reset,
   udiv64_req_if req_mon,
   udiv64_rsp_if rsp_mon,
   input  logic  end_of_test,
   output int    outstanding,
   output int    mismatch_count
);

   typedef struct packed {
      logic [W-1:0] quotient;
      logic [W-1:0] remainder;
      logic         divide_by_zero;
   } division_result_type;

   division_result_type pending_divisions[$];
   bit                  leftovers_checked;

   initial begin
      outstanding       = 0;
      mismatch_count    = 0;
      leftovers_checked = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic division_result_type predict_division(input logic [W-1:0] num,
                                                            input logic [W-1:0] den);
      division_result_type res;
      logic [W-1:0]        part;
      logic [W-1:0]        quo;
      logic                carry;
      res  = '0;
      part = '0;
      quo  = '0;
      if (den == '0) begin
         res.divide_by_zero = 1'b1;
      end else if (den > num) begin
         res.remainder = num;
      end else begin
         for (int i = W - 1; i >= 0; i--) begin
            carry = part[W-1];
            part  = {part[W-2:0], num[i]};
            quo   = {quo[W-2:0], 1'b0};
            if (carry || part >= den) begin
               part   = part - den;
               quo[0] = 1'b1;
            end
         end
         res.quotient  = quo;
         res.remainder = part;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      division_result_type want;
      string               msg;
      if (!reset) begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            pending_divisions.push_back(predict_division(req_mon.dividend, req_mon.divisor));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (pending_divisions.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = pending_divisions.pop_front();
               msg  = "";
               if (rsp_mon.quotient !== want.quotient) begin
                  msg = {msg, $sformatf(" quotient %h (exp %h)",
                                        rsp_mon.quotient, want.quotient)};
               end
               if (rsp_mon.remainder !== want.remainder) begin
                  msg = {msg, $sformatf(" remainder %h (exp %h)",
                                        rsp_mon.remainder, want.remainder)};
               end
               if (rsp_mon.divide_by_zero !== want.divide_by_zero) begin
                  msg = {msg, $sformatf(" divide_by_zero %b (exp %b)",
                                        rsp_mon.divide_by_zero, want.divide_by_zero)};
               end
               if (msg != "") begin
                  report_mismatch({"response mismatch:", msg});
               end
            end
         end
         if (end_of_test && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (pending_divisions.size() != 0) begin
               report_mismatch($sformatf("%0d expected responses never arrived",
                                         pending_divisions.size()));
            end
         end
      end
      outstanding = pending_divisions.size();
   end

endmodule

FILE: tb/unsigned_divide_64_tb.sv
`timescale 1ns / 1ps

module unsigned_divide_64_tb;

   localparam int W            = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock = 1'b0;
   logic reset;
   logic end_of_test;
   bit   idling_on;
   int   outstanding;
   int   mismatch_count;
   int   cycle_count = 0;

   logic [W-1:0] num;
   logic [W-1:0] den;

   udiv64_req_if #(.DATA_WIDTH(W)) req_bus ();
   udiv64_rsp_if #(.DATA_WIDTH(W)) rsp_bus ();

   unsigned_divide_64 #(.DATA_WIDTH(W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   udiv64_checker #(.W(W)) chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .end_of_test    (end_of_test),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [W-1:0] random_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw >> $urandom_range(0, W - 1);
   endfunction

   task automatic send_division(input logic [W-1:0] dividend, input logic [W-1:0] divisor);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.dividend <= dividend;
      req_bus.divisor  <= divisor;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // The receiver stalls in short random bursts while idling is enabled.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      reset            = 1'b1;
      end_of_test      = 1'b0;
      idling_on        = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.dividend = '0;
      req_bus.divisor  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_division('0, '0);
      send_division('1, '0);
      send_division('0, 64'd1);
      send_division('1, 64'd1);
      send_division('1, '1);
      send_division(64'hFFFF_FFFF_FFFF_FFFE, '1);
      send_division(64'd1, '1);
      send_division('1, 64'd2);
      send_division(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send_division('1, 64'h8000_0000_0000_0001);
      send_division(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
      send_division('1, 64'h8000_0000_0000_0000);
      send_division(64'h8000_0000_0000_0000, 64'd3);
      send_division(64'd12345, 64'd12345);
      send_division(64'd100, 64'd7);
      send_division(64'd7, 64'd100);
      send_division('1, 64'h0000_0000_FFFF_FFFF);
      send_division(64'h0123_4567_89AB_CDEF, 64'h10);
      send_division(64'hFEDC_BA98_7654_3210, 64'h0000_0001_0000_0001);
      send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

      // The sender holds off here until every response has come back.
      wait_for_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idling_on = (i < RANDOM_ITEMS - 150) && ((i / 150) % 3 != 2);
         if (i == RANDOM_ITEMS / 2) begin
            wait_for_responses();
         end
         case ($urandom_range(0, 9))
            0: begin
               num = random_word();
               den = '0;
            end
            1: begin
               num = {$urandom, $urandom};
               den = {$urandom, $urandom};
            end
            2, 3: begin
               num = {$urandom, $urandom};
               den = random_word();
            end
            4: begin
               num = {$urandom, $urandom};
               den = num + W'($urandom_range(0, 2)) - W'(1);
            end
            5: begin
               num = {$urandom, $urandom};
               den = W'({1'b1, random_word()} >> 1);
            end
            default: begin
               num = random_word();
               den = random_word();
            end
         endcase
         send_division(num, den);
      end

      wait_for_responses();
      repeat (W + 8) @(negedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
